// ----- src/mf3_pkg.sv -----
// mf3_pkg: shared types, constants and median helpers for the 3x3 median filter.
// No dependencies; imported by the filter core and its checker.
package mf3_pkg;

  localparam int PIX_W = 8;
  localparam int REG_W = 13;
  localparam int CFG_IDX_W = 1;

  localparam int MAX_ROW_BYTES_DEF = 4096;
  localparam int MAX_ROWS_DEF = 4096;

  localparam logic [REG_W-1:0] ROW_BYTES_RST = REG_W'(1920);
  localparam logic [REG_W-1:0] ROW_COUNT_RST = REG_W'(480);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROW_BYTES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 1'b1;

  // input action codes
  localparam logic ACTION_PIXEL = 1'b0;
  localparam logic ACTION_DRAIN = 1'b1;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    logic action;
    pix_t pixel_value;
  } in_beat_t;

  typedef struct packed {
    pix_t out_pixel;
    logic out_last;
  } out_beat_t;

  // per-beat output decision, carried along the pipeline
  typedef struct packed {
    logic produce;
    logic interior;
    logic last;
  } pos_info_t;

  function automatic pix_t min2(pix_t a, pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pix_t max2(pix_t a, pix_t b);
    return (a < b) ? b : a;
  endfunction

  function automatic pix_t min3(pix_t a, pix_t b, pix_t c);
    return min2(min2(a, b), c);
  endfunction

  function automatic pix_t max3(pix_t a, pix_t b, pix_t c);
    return max2(max2(a, b), c);
  endfunction

  function automatic pix_t med3(pix_t a, pix_t b, pix_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  // Row sort, then median of (max of mins, median of medians, min of maxes).
  function automatic pix_t median9(pix_t w0, pix_t w1, pix_t w2,
                                   pix_t w3, pix_t w4, pix_t w5,
                                   pix_t w6, pix_t w7, pix_t w8);
    pix_t lo_max;
    pix_t mid_med;
    pix_t hi_min;
    lo_max  = max3(min3(w0, w1, w2), min3(w3, w4, w5), min3(w6, w7, w8));
    mid_med = med3(med3(w0, w1, w2), med3(w3, w4, w5), med3(w6, w7, w8));
    hi_min  = min3(max3(w0, w1, w2), max3(w3, w4, w5), max3(w6, w7, w8));
    return med3(lo_max, mid_med, hi_min);
  endfunction

endpackage

// ----- src/median_filter_3x3_core.sv -----
// median_filter_3x3_core: streaming 3x3 median filter, two line memories and a window.
// Depends on mf3_pkg (beat types, register indexes, median9).
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+---------------------------------
//  in      | sink      | in_valid_i / in_stall_o | in_data_i   (action, pixel_value)
//  out     | source    | out_valid_o/out_stall_i | out_data_o  (out_pixel, out_last)
//  cfg     | sink      | cfg_we_i                | cfg_idx_i, cfg_wdata_i
//
// One beat per clock sustained while the output is not stalled. Three register stages from accept to the result
// register: line memory read, window shift, median into the output register; the
// median network sits between the window and the output register.
// A result belongs to the position row_bytes+1 beats earlier in the stream.
// Reset clears position, window and the pipeline; the line memories are not cleared.
// An output stall on a valid result freezes the whole pipeline and raises in_stall_o in the same cycle.
module median_filter_3x3_core
  import mf3_pkg::*;
#(
  parameter int MAX_ROW_BYTES = MAX_ROW_BYTES_DEF,
  parameter int MAX_ROWS      = MAX_ROWS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_beat_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_beat_t            out_data_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [REG_W-1:0]     cfg_wdata_i
);

  // column address, row-length and row-count widths
  localparam int CW   = $clog2(MAX_ROW_BYTES);
  localparam int WW   = $clog2(MAX_ROW_BYTES + 1);
  localparam int HW   = $clog2(MAX_ROWS + 1);
  localparam int RW   = $clog2(MAX_ROWS + 2);
  localparam int CMPW = (REG_W > WW) ? REG_W : WW;
  localparam int CMPH = (REG_W > HW) ? REG_W : HW;

  // configuration
  logic [REG_W-1:0] row_bytes_q;
  logic [REG_W-1:0] row_count_q;

  // input position
  logic [CW-1:0] in_col_q, in_col_d;
  logic [RW-1:0] in_row_q, in_row_d;

  // stage 1: beat plus line memory read data
  logic          s1_valid_q;
  logic          s1_drain_q;
  pix_t          s1_pix_q;
  logic [CW-1:0] s1_col_q;
  pos_info_t     s1_info_q;
  pix_t          rd_up_q;
  pix_t          rd_mid_q;

  // stage 2: window of original bytes
  logic      s2_valid_q;
  pos_info_t s2_info_q;
  pix_t      win_q [9];

  // output register
  logic      out_valid_q;
  out_beat_t out_q;

  // line memories
  pix_t up_mem  [MAX_ROW_BYTES];
  pix_t mid_mem [MAX_ROW_BYTES];

  logic      adv;
  logic      accept;
  logic      mem_we;
  pos_info_t info_d;

  logic [CMPW-1:0] rb_ext;
  logic [CMPH-1:0] rc_ext;
  logic [WW-1:0]   w_eff;
  logic [HW-1:0]   h_eff;
  logic            col_nz;
  logic [RW-1:0]   orow;
  logic [CW-1:0]   ocol;
  logic [WW-1:0]   ocol_ext;
  logic [RW-1:0]   h_ext;
  logic [WW-1:0]   col_inc;
  pix_t            med;

  // Advance every stage together unless the result register is stuck.
  assign adv    = !out_valid_q || !out_stall_i;
  assign accept = in_valid_i && adv;
  assign mem_we = adv && s1_valid_q && (s1_drain_q != ACTION_DRAIN);

  assign in_stall_o  = !adv;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Saturate the row geometry to the supported range.
  always_comb begin
    rb_ext = CMPW'(row_bytes_q);
    rc_ext = CMPH'(row_count_q);
    if (rb_ext < CMPW'(3)) begin
      w_eff = WW'(3);
    end else if (rb_ext > CMPW'(MAX_ROW_BYTES)) begin
      w_eff = WW'(MAX_ROW_BYTES);
    end else begin
      w_eff = rb_ext[WW-1:0];
    end
    if (rc_ext < CMPH'(3)) begin
      h_eff = HW'(3);
    end else if (rc_ext > CMPH'(MAX_ROWS)) begin
      h_eff = HW'(MAX_ROWS);
    end else begin
      h_eff = rc_ext[HW-1:0];
    end
  end

  // Output position of the accepted beat and its border/last flags.
  always_comb begin
    col_nz         = (in_col_q != '0);
    info_d.produce = (in_row_q >= RW'(2)) || ((in_row_q == RW'(1)) && col_nz);
    if (col_nz) begin
      orow = in_row_q - RW'(1);
      ocol = in_col_q - CW'(1);
    end else begin
      orow = in_row_q - RW'(2);
      ocol = CW'(w_eff - WW'(1));
    end
    ocol_ext        = WW'(ocol);
    h_ext           = RW'(h_eff);
    info_d.interior = (orow != '0) && (orow <= h_ext - RW'(2)) &&
                      (ocol != '0) && (ocol_ext <= w_eff - WW'(2));
    info_d.last     = (orow == h_ext - RW'(1)) && (ocol_ext == w_eff - WW'(1));

    // advance the position; restart after the final result of the frame
    col_inc  = WW'(in_col_q) + WW'(1);
    in_col_d = in_col_q;
    in_row_d = in_row_q;
    if (accept) begin
      if (info_d.produce && info_d.last) begin
        in_col_d = '0;
        in_row_d = '0;
      end else if (col_inc == w_eff) begin
        in_col_d = '0;
        in_row_d = in_row_q + RW'(1);
      end else begin
        in_col_d = col_inc[CW-1:0];
      end
    end
  end

  // Configuration registers and position; a write restarts the frame.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_bytes_q <= ROW_BYTES_RST;
      row_count_q <= ROW_COUNT_RST;
      in_col_q    <= '0;
      in_row_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ROW_BYTES: row_bytes_q <= cfg_wdata_i;
        REG_ROW_COUNT: row_count_q <= cfg_wdata_i;
        default: ;
      endcase
      in_col_q <= '0;
      in_row_q <= '0;
    end else begin
      in_col_q <= in_col_d;
      in_row_q <= in_row_d;
    end
  end

  // Line memories: read at accept, write back from stage 1 as the beat moves on.
  // Within a row a column comes back only after the write. Right after the final
  // result of a frame column zero follows column zero, so take the pending write
  // data instead of the stale memory word.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (mem_we && (s1_col_q == in_col_q)) begin
        rd_up_q  <= rd_mid_q;
        rd_mid_q <= s1_pix_q;
      end else begin
        rd_up_q  <= up_mem[in_col_q];
        rd_mid_q <= mid_mem[in_col_q];
      end
    end
    if (mem_we) begin
      up_mem[s1_col_q]  <= rd_mid_q;
      mid_mem[s1_col_q] <= s1_pix_q;
    end
  end

  // Pipeline valid bits and window.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= '0;
      end
    end else if (adv) begin
      s1_valid_q  <= accept;
      s2_valid_q  <= s1_valid_q && s1_info_q.produce;
      out_valid_q <= s2_valid_q;
      if (s1_valid_q) begin
        // shift in a new column: upper row, middle row, current byte
        for (int r = 0; r < 3; r++) begin
          win_q[r*3]   <= win_q[r*3+1];
          win_q[r*3+1] <= win_q[r*3+2];
        end
        win_q[2] <= rd_up_q;
        win_q[5] <= rd_mid_q;
        win_q[8] <= (s1_drain_q == ACTION_DRAIN) ? '0 : s1_pix_q;
      end
    end
  end

  assign med = median9(win_q[0], win_q[1], win_q[2], win_q[3], win_q[4],
                       win_q[5], win_q[6], win_q[7], win_q[8]);

  // Payload registers; hold while stalled.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_drain_q          <= in_data_i.action;
      s1_pix_q            <= in_data_i.pixel_value;
      s1_col_q            <= in_col_q;
      s1_info_q           <= info_d;
      s2_info_q           <= s1_info_q;
      out_q.out_pixel     <= s2_info_q.interior ? med : win_q[4];
      out_q.out_last      <= s2_info_q.last;
    end
  end

endmodule

// ----- src/mf3_checker.sv -----
// mf3_checker: port-level assertions for median_filter_3x3_core, bound into that module.
// Depends on mf3_pkg for the beat types.
module mf3_checker
  import mf3_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_beat_t out_data_o
);

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // result holds while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped or changed under stall");

  // input side stalls only behind a stuck result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a stuck result");

  // input stall follows the output stall in the same cycle
  a_stall_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input accepted while result is stuck");

  // the pipeline empties when no input is accepted and the output is not stalled
  a_drain_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!in_acc, 1) && $past(!in_acc, 2) && $past(!in_acc, 3) &&
    $past(!out_stall_i, 1) && $past(!out_stall_i, 2) && $past(!out_stall_i, 3)
    |-> !out_valid_o)
    else $error("result without an accepted input");

endmodule

bind median_filter_3x3_core mf3_checker u_mf3_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
